### src/kth_pkg.sv
// Shared constants, state type and helper function of the kth-largest tracker.
package kth_pkg;

  // Heap depth and the widths that follow from it.
  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int RANK_W   = 11;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = CNT_W + 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_EMIT
  } kth_state_t;

  // A rank of zero acts as one, and a rank above the heap depth saturates.
  function automatic logic [CNT_W-1:0] effective_k(input logic [RANK_W-1:0] rank);
    logic [CNT_W-1:0] k;
    if (rank == '0) begin
      k = CNT_W'(1);
    end else if (32'(rank) > CAPACITY) begin
      k = CNT_W'(CAPACITY);
    end else begin
      k = CNT_W'(rank);
    end
    return k;
  endfunction

endpackage

### src/kth_ram.sv
// Generic RAM with one write port and two registered read ports.
module kth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]                          rd_data_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                          rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Both read ports are registered: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### src/kth_largest_stream_tracker.sv
// Top level of the kth-largest tracker: heap sequencer, heap RAM and output register.
//
// Usage:
//   The input channel (in_valid / in_ready / sample_value) takes one signed
//   32-bit request at a time. The block keeps a binary min-heap in a RAM that
//   holds the k largest values seen so far and, for each request, returns one
//   result on the output channel (out_valid / out_ready / kth_largest,
//   heap_full): the heap root and a flag that is high once k values are stored.
//   The configuration channel (cfg_valid / cfg_ready / rank_k) sets k; it is
//   always ready; the user writes it only while no request is in flight, as the block itself does not enforce it.
//   An append walks up the heap and a root replacement walks down it, each
//   level taking a RAM read state and a compare-and-write state; a dropped
//   sample goes straight from idle to the output state.
//   Throughput is one request per walk, since in_ready is high only while the
//   sequencer is idle.
//   Reset clears the fill count, sets k to 1 and empties the output register.
//   When the receiver stalls, the result waits in the output register; the next
//   request is still taken and processed, and its result waits until the slot
//   frees up.
module kth_largest_stream_tracker
  import kth_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RANK_W-1:0]        rank_k,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sample_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] kth_largest,
  output logic                     heap_full
);

  kth_state_t state, state_next;

  logic [RANK_W-1:0]        rank;
  logic [CNT_W-1:0]         fill, fill_next;
  logic [ADDR_W-1:0]        pos, pos_next;
  logic signed [DATA_W-1:0] v, v_next;
  logic signed [DATA_W-1:0] root;
  logic [CNT_W-1:0]         k_eff;
  logic                     load_out;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_ra;
  logic [ADDR_W-1:0]        ram_rb;
  logic [DATA_W-1:0]        ram_rd_a;
  logic [DATA_W-1:0]        ram_rd_b;

  logic [ADDR_W-1:0]        parent;
  logic [IDX_W-1:0]         l_idx;
  logic [IDX_W-1:0]         r_idx;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic                     up_gt;
  logic                     take_l;
  logic                     take_r;
  logic signed [DATA_W-1:0] best;

  // Heap storage.
  kth_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr_a (ram_ra),
    .rd_data_a (ram_rd_a),
    .rd_addr_b (ram_rb),
    .rd_data_b (ram_rd_b)
  );

  assign cfg_ready = 1'b1;
  assign k_eff     = effective_k(rank);

  // Heap index arithmetic and the compare logic.
  assign parent = (pos - ADDR_W'(1)) >> 1;
  assign l_idx  = IDX_W'({pos, 1'b1});
  assign r_idx  = l_idx + IDX_W'(1);
  assign rd_a   = $signed(ram_rd_a);
  assign rd_b   = $signed(ram_rd_b);
  assign up_gt  = rd_a > v;
  assign take_l = (l_idx < IDX_W'(fill)) && (rd_a < v);
  assign best   = take_l ? rd_a : v;
  assign take_r = (r_idx < IDX_W'(fill)) && (rd_b < best);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (fill < k_eff) begin
            state_next = ST_UP_RD;
          end else if (sample_value > root) begin
            state_next = ST_DN_RD;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_UP_RD: begin
        state_next = (pos == '0) ? ST_EMIT : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_next = up_gt ? ST_UP_RD : ST_EMIT;
      end
      ST_DN_RD: begin
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_next = (take_l || take_r) ? ST_DN_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls and next values of the working registers.
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = v;
    ram_ra    = parent;
    ram_rb    = r_idx[ADDR_W-1:0];
    pos_next  = pos;
    fill_next = fill;
    v_next    = v;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          v_next = sample_value;
          if (fill < k_eff) begin
            pos_next  = fill[ADDR_W-1:0];
            fill_next = fill + CNT_W'(1);
          end else begin
            pos_next = '0;
          end
        end
      end
      ST_UP_RD: begin
        // The hole reached the root: the new value lands there.
        if (pos == '0) begin
          ram_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (up_gt) begin
          ram_wdata = ram_rd_a;
          pos_next  = parent;
        end
      end
      ST_DN_RD: begin
        ram_ra = l_idx[ADDR_W-1:0];
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (take_r) begin
          ram_wdata = ram_rd_b;
          pos_next  = r_idx[ADDR_W-1:0];
        end else if (take_l) begin
          ram_wdata = ram_rd_a;
          pos_next  = l_idx[ADDR_W-1:0];
        end
      end
      ST_EMIT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rank      <= RANK_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_valid) begin
        rank <= rank_k;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and a copy of the heap root.
  always_ff @(posedge clk) begin
    pos <= pos_next;
    v   <= v_next;
    if (ram_we && ram_waddr == '0) begin
      root <= $signed(ram_wdata);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      kth_largest <= root;
      heap_full   <= (fill >= k_eff);
    end
  end

  // The fill count never passes the heap depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("fill count above heap depth");

  // A request never shrinks the heap.
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> fill >= $past(fill))
    else $error("fill count decreased on a request");

  // The sift-up hole always sits inside the filled part of the heap.
  a_up_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_RD || state == ST_UP_CMP) |-> CNT_W'(pos) < fill)
    else $error("sift-up position outside the heap");

  // The sift-down hole always sits inside the filled part of the heap.
  a_dn_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_RD || state == ST_DN_CMP) |-> CNT_W'(pos) < fill)
    else $error("sift-down position outside the heap");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the kth-largest stream tracker, with a heap predictor.
module tb_top
  import kth_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 30;
  localparam int NUM_PHASES  = 10;

  // Rank settings of the random part and the number of samples sent under each.
  localparam int PHASE_RANK [NUM_PHASES] = '{2, 5, 17, 64, 300, 1024, 2047, 0, 1025, 600};
  localparam int PHASE_LEN  [NUM_PHASES] = '{40, 60, 80, 150, 300, 800, 150, 100, 100, 120};
  localparam int PAUSE_PHASE = 3;
  localparam int HOLD_PHASE  = 4;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_RANK} row_kind_t;
  typedef enum logic [1:0] {PICK_ANY, PICK_NEAR_ZERO, PICK_EXTREME, PICK_NEAR_ROOT} pick_mode_t;
  typedef enum logic [2:0] {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic                     full;
  } root_result_t;

  // One directed step: a sample request, or a rank write (value in val).
  typedef struct packed {
    row_kind_t                kind;
    logic signed [DATA_W-1:0] val;
    logic                     typed;
    logic signed [DATA_W-1:0] exp_kth;
    logic                     exp_full;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    // Rank 1 after reset: a single-entry heap that keeps the maximum.
    '{ROW_SAMPLE, -32'sd5, 1'b1, -32'sd5, 1'b1},
    '{ROW_SAMPLE, INT_MIN, 1'b1, -32'sd5, 1'b1},
    '{ROW_SAMPLE, -32'sd5, 1'b1, -32'sd5, 1'b1},
    '{ROW_SAMPLE, INT_MAX, 1'b1, INT_MAX, 1'b1},
    // Rank 3: append until full, then a replacement and a tie.
    '{ROW_RANK,   32'sd3,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'sd10, 1'b1, 32'sd10, 1'b0},
    '{ROW_SAMPLE, INT_MIN, 1'b1, INT_MIN, 1'b1},
    '{ROW_SAMPLE, 32'sd7,  1'b1, 32'sd7, 1'b1},
    '{ROW_SAMPLE, 32'sd7,  1'b1, 32'sd7, 1'b1},
    // Rank zero acts as one, and is below the fill count.
    '{ROW_RANK,   32'sd0,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'sd8,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, -32'sd1, 1'b0, 32'sd0, 1'b0},
    // Rank above the heap depth saturates.
    '{ROW_RANK,   32'sd2047, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, -32'sd100, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'sh5555_5555, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'shAAAA_AAAA, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'sd0,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, INT_MIN, 1'b0, 32'sd0, 1'b0},
    '{ROW_RANK,   32'sd1025, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, 32'sd1,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, INT_MAX, 1'b0, 32'sd0, 1'b0},
    // Rank lowered to one while many entries are stored.
    '{ROW_RANK,   32'sd1,  1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, INT_MAX, 1'b0, 32'sd0, 1'b0},
    '{ROW_SAMPLE, -32'sd2, 1'b0, 32'sd0, 1'b0}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [RANK_W-1:0]        rank_k;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] sample_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] kth_largest;
  logic                     heap_full;

  // Predictor state: heap contents, fill count and the rank register.
  logic signed [DATA_W-1:0] heap_vals [];
  int unsigned              heap_count;
  logic [RANK_W-1:0]        rank_reg;

  root_result_t root_results_q [$];
  int  mismatches;
  int  results_checked;
  int  samples_sent;
  int  rank_writes;
  int  cycle_count;
  bit  hold_request;
  bit  hold_done;

  kth_largest_stream_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .rank_k       (rank_k),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kth_largest  (kth_largest),
    .heap_full    (heap_full)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Global watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, root_results_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Applies one sample to the heap and returns the root and the full flag.
  function automatic root_result_t heap_accept(input logic signed [DATA_W-1:0] v);
    int unsigned              k;
    int unsigned              pos;
    int unsigned              up;
    int unsigned              lc;
    int unsigned              rc;
    int unsigned              m;
    bit                       done;
    logic signed [DATA_W-1:0] t;
    root_result_t             res;
    k = (rank_reg == '0) ? 1 : ((rank_reg > CAPACITY) ? CAPACITY : rank_reg);
    done = 1'b0;
    if (heap_count < k) begin
      // Append at the end and move up while the parent is larger.
      pos = heap_count;
      heap_vals[pos] = v;
      while (pos > 0 && !done) begin
        up = (pos - 1) / 2;
        if (heap_vals[up] > heap_vals[pos]) begin
          t = heap_vals[up];
          heap_vals[up] = heap_vals[pos];
          heap_vals[pos] = t;
          pos = up;
        end else begin
          done = 1'b1;
        end
      end
      heap_count++;
    end else if (v > heap_vals[0]) begin
      // Replace the root and move down toward the smaller child.
      heap_vals[0] = v;
      pos = 0;
      while (!done) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        m = pos;
        if (lc < heap_count && heap_vals[lc] < heap_vals[m]) m = lc;
        if (rc < heap_count && heap_vals[rc] < heap_vals[m]) m = rc;
        if (m == pos) begin
          done = 1'b1;
        end else begin
          t = heap_vals[pos];
          heap_vals[pos] = heap_vals[m];
          heap_vals[m] = t;
          pos = m;
        end
      end
    end
    res.kth = heap_vals[0];
    res.full = (heap_count >= k);
    return res;
  endfunction

  // Random sample: any value, a value near zero, an extreme, or a value near the current root.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    pick_mode_t mode;
    longint     w;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) mode = PICK_ANY;
    else if (roll < 6) mode = PICK_NEAR_ZERO;
    else if (roll < 7) mode = PICK_EXTREME;
    else mode = PICK_NEAR_ROOT;
    case (mode)
      PICK_ANY: begin
        return $urandom();
      end
      PICK_NEAR_ZERO: begin
        return $signed(DATA_W'($urandom_range(0, 127))) - 64;
      end
      PICK_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: begin
        w = longint'(heap_vals[0]) + longint'($urandom_range(0, 2000)) - 500;
        if (w > INT_MAX) w = INT_MAX;
        if (w < INT_MIN) w = INT_MIN;
        return DATA_W'(w);
      end
    endcase
  endfunction

  // Offers one sample request and records its expected result once accepted.
  task automatic send_sample(input logic signed [DATA_W-1:0] v, input logic typed,
                             input root_result_t typed_res);
    root_result_t res;
    @(negedge clk);
    in_valid = 1'b1;
    sample_value = v;
    do @(posedge clk); while (!in_ready);
    res = heap_accept(v);
    root_results_q.push_back(typed ? typed_res : res);
    samples_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (root_results_q.size() != 0) @(negedge clk);
  endtask

  // Writes the rank register through the configuration channel.
  task automatic write_rank(input logic [RANK_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    rank_k = v;
    do @(posedge clk); while (!cfg_ready);
    rank_reg = v;
    rank_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result receiver: stall pattern of its own, plus one long hold-off on request.
  initial begin : result_sink
    sink_mode_t mode;
    int         seg_left;
    int         hold_left;
    out_ready = 1'b0;
    mode = SINK_OPEN;
    seg_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ready = 1'b0;
        for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) @(negedge clk);
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 4));
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      case (mode)
        SINK_OPEN:   out_ready = 1'b1;
        SINK_COIN:   out_ready = 1'($urandom_range(0, 1));
        SINK_MOSTLY: out_ready = ($urandom_range(0, 7) != 0);
        SINK_SPARSE: out_ready = ($urandom_range(0, 7) == 0);
        default:     out_ready = ~out_ready;
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    root_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (root_results_q.size() == 0) begin
        $error("Result with no request outstanding: kth_largest %0d, heap_full %0b",
               kth_largest, heap_full);
        mismatches++;
      end else begin
        exp_res = root_results_q.pop_front();
        results_checked++;
        if (kth_largest !== exp_res.kth) begin
          $error("kth_largest: expected %0d, got %0d", exp_res.kth, kth_largest);
          mismatches++;
        end
        if (heap_full !== exp_res.full) begin
          $error("heap_full: expected %0b, got %0b", exp_res.full, heap_full);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases over several ranks.
  initial begin : stimulus
    int        ph;
    int        sent;
    int        burst;
    int        gap;
    dir_row_t  row;
    root_result_t typed_res;
    rst = 1'b1;
    cfg_valid = 1'b0;
    rank_k = '0;
    in_valid = 1'b0;
    sample_value = '0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    mismatches = 0;
    results_checked = 0;
    samples_sent = 0;
    rank_writes = 0;
    cycle_count = 0;
    heap_vals = new[CAPACITY];
    heap_count = 0;
    rank_reg = RANK_W'(1);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: rank writes wait for the block to go idle first.
    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_RANK) begin
        wait_drained();
        write_rank(row.val[RANK_W-1:0]);
      end else begin
        typed_res.kth = row.exp_kth;
        typed_res.full = row.exp_full;
        send_sample(row.val, row.typed, typed_res);
      end
    end

    // Random part: bursts with random gaps, one rank setting per phase.
    typed_res = '0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_rank(RANK_W'(PHASE_RANK[ph]));
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_LEN[ph]) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && sent < PHASE_LEN[ph]) begin
          send_sample(pick_sample(), 1'b0, typed_res);
          sent++;
          burst--;
          // Once in the run, stop mid-phase until all results are back.
          if (ph == PAUSE_PHASE && sent == PHASE_LEN[ph] / 2) wait_drained();
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d samples under %0d rank writes; %0d results checked.",
             samples_sent, rank_writes, results_checked);
    $display("Heap fill reached %0d of %0d entries; ranks from zero to saturation.",
             heap_count, CAPACITY);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
